@@ hw/rtl/ufg_pkg.sv @@
// shared types and constants of the frame level gauge
package ufg_pkg;

   // frame bytes and byte phases
   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam logic [1:0] PH_HUNT     = 2'd0;
   localparam logic [1:0] PH_HIGH     = 2'd1;
   localparam logic [1:0] PH_LOW      = 2'd2;
   localparam logic [1:0] PH_SUM      = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_MIN_RANGE  = 2'd0;
   localparam logic [1:0] CSR_SPAN       = 2'd1;
   localparam logic [1:0] CSR_BAR_HEIGHT = 2'd2;

   // configuration reset values
   localparam logic [15:0] MIN_RANGE_RST  = 16'd30;
   localparam logic [15:0] SPAN_RST       = 16'd500;
   localparam logic [7:0]  BAR_HEIGHT_RST = 8'd87;

   // divider geometry: scaled excess is at most 65535 * 100
   localparam int unsigned DIV_WIDTH = 23;
   localparam logic [4:0]  DIV_LAST_COUNT = 5'(DIV_WIDTH - 1);

   // percent scaling
   localparam logic [6:0]  FULL_PCT   = 7'd100;
   localparam logic [12:0] RECIP_100  = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 19;

   // text positions by digit count
   localparam logic [4:0] TEXT_X_ONE   = 5'd22;
   localparam logic [4:0] TEXT_X_TWO   = 5'd16;
   localparam logic [4:0] TEXT_X_THREE = 5'd10;

   // controller to datapath commands
   typedef struct packed {
      logic load_high;
      logic load_low;
      logic start;
      logic div_step;
      logic scale;
      logic recip;
      logic load_out;
   } ufg_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_header;
      logic sum_match;
      logic out_free;
   } ufg_status_type;

endpackage

@@ hw/rtl/ultrasonic_frame_level_gauge.sv @@
// Header, high and low bytes are taken one per cycle while req_stall is low and give no result.
// A checksum byte with a bad sum goes to the write state and its result is loaded from there; a good
// frame first runs the 23-step bit-serial divider, then scaling, then the multiply, then the write state.
// req_stall is high from the checksum transfer until the result is loaded, also while the result
// register is stalled.
// Synchronous reset clears byte phase, sequencer and result valid, loads register defaults.
module ultrasonic_frame_level_gauge
   import ufg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_status,
   output logic [15:0] rsp_distance_mm,
   output logic [6:0]  rsp_fill_percent,
   output logic [7:0]  rsp_liquid_px,
   output logic [4:0]  rsp_text_x,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ufg_cmd_type    cmd;
   ufg_status_type status;

   // sequencer
   ufg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   ufg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_rx_byte      (req_rx_byte),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_status (rsp_frame_status),
      .rsp_distance_mm  (rsp_distance_mm),
      .rsp_fill_percent (rsp_fill_percent),
      .rsp_liquid_px    (rsp_liquid_px),
      .rsp_text_x       (rsp_text_x)
   );

endmodule

@@ hw/rtl/ufg_ctrl.sv @@
// controller: byte phase tracking and compute sequencing
module ufg_ctrl
   import ufg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ufg_status_type status,
   output ufg_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_SCALE = 5'b00100,
      ST_RECIP = 5'b01000,
      ST_WRITE = 5'b10000
   } ufg_state_type;

   ufg_state_type state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [4:0]    cnt_ff, cnt_in;

   // input is taken only while idle
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (phase_ff)
                  PH_HUNT: begin
                     if (status.is_header) begin
                        phase_in = PH_HIGH;
                     end
                  end
                  PH_HIGH: begin
                     cmd.load_high = 1'b1;
                     phase_in      = PH_LOW;
                  end
                  PH_LOW: begin
                     cmd.load_low = 1'b1;
                     phase_in     = PH_SUM;
                  end
                  default: begin
                     cmd.start = 1'b1;
                     phase_in  = PH_HUNT;
                     cnt_in    = DIV_LAST_COUNT;
                     state_in  = status.sum_match ? ST_DIV : ST_WRITE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_SCALE;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_RECIP;
         end
         ST_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_HUNT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ hw/rtl/ufg_dp.sv @@
// datapath: frame bytes, config registers, divider, scaling and result register
module ufg_dp
   import ufg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     req_rx_byte,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_wdata,
   input  ufg_cmd_type    cmd,
   output ufg_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_frame_status,
   output logic [15:0]    rsp_distance_mm,
   output logic [6:0]     rsp_fill_percent,
   output logic [7:0]     rsp_liquid_px,
   output logic [4:0]     rsp_text_x
);

   logic [15:0]          min_range_ff;
   logic [15:0]          span_ff;
   logic [7:0]           bar_height_ff;
   logic [7:0]           high_ff;
   logic [7:0]           low_ff;
   logic                 bad_ff;
   logic                 below_min_ff;
   logic [15:0]          div_ff;
   logic [15:0]          rem_ff, rem_in;
   logic [DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [6:0]           pct_ff, pct_in;
   logic [14:0]          prod_ff;
   logic [27:0]          recip_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_status_ff;
   logic [15:0]          rsp_dist_ff;
   logic [6:0]           rsp_pct_ff;
   logic [7:0]           rsp_liquid_ff;
   logic [4:0]           rsp_text_x_ff;

   logic [15:0]          dist_mm;
   logic [15:0]          excess;
   logic [DIV_WIDTH-1:0] excess_x100;
   logic [16:0]          trial;
   logic                 trial_ge;
   logic                 rem_nz;
   logic                 steps_ge_full;
   logic [4:0]           text_x;

   // status toward the controller
   assign dist_mm          = {high_ff, low_ff};
   assign status.is_header = (req_rx_byte == HEADER_BYTE);
   assign status.sum_match = (8'(HEADER_BYTE + high_ff + low_ff) == req_rx_byte);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // scaled excess: excess * 100 as shift-adds
   assign excess      = dist_mm - min_range_ff;
   assign excess_x100 = (DIV_WIDTH'(excess) << 6) + (DIV_WIDTH'(excess) << 5)
                      + (DIV_WIDTH'(excess) << 2);

   // one restoring division step
   assign trial    = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign trial_ge = (trial >= {1'b0, div_ff});
   always_comb begin
      rem_in = trial_ge ? 16'(trial - {1'b0, div_ff}) : trial[15:0];
      quo_in = {quo_ff[DIV_WIDTH-2:0], trial_ge};
   end

   // fill percent: 100 at or below the minimum range, else 100 minus ceiling of the quotient, clamped at zero
   assign rem_nz        = (rem_ff != 16'd0);
   assign steps_ge_full = (quo_ff >= DIV_WIDTH'(FULL_PCT))
                        || ((quo_ff == DIV_WIDTH'(FULL_PCT - 7'd1)) && rem_nz);
   always_comb begin
      if (below_min_ff) begin
         pct_in = FULL_PCT;
      end else if (steps_ge_full) begin
         pct_in = 7'd0;
      end else begin
         pct_in = FULL_PCT - quo_ff[6:0] - {6'd0, rem_nz};
      end
   end

   // text position by digit count
   always_comb begin
      if (pct_ff < 7'd10) begin
         text_x = TEXT_X_ONE;
      end else if (pct_ff < FULL_PCT) begin
         text_x = TEXT_X_TWO;
      end else begin
         text_x = TEXT_X_THREE;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff  <= MIN_RANGE_RST;
         span_ff       <= SPAN_RST;
         bar_height_ff <= BAR_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_RANGE:  min_range_ff  <= csr_wdata;
            CSR_SPAN:       span_ff       <= csr_wdata;
            CSR_BAR_HEIGHT: bar_height_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // frame bytes, divider and scaling pipeline
   always_ff @(posedge clock) begin
      if (cmd.load_high) begin
         high_ff <= req_rx_byte;
      end
      if (cmd.load_low) begin
         low_ff <= req_rx_byte;
      end
      if (cmd.start) begin
         bad_ff       <= !status.sum_match;
         below_min_ff <= (dist_mm <= min_range_ff);
         div_ff       <= (span_ff == 16'd0) ? 16'd1 : span_ff;
         rem_ff       <= '0;
         quo_ff       <= excess_x100;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.scale) begin
         pct_ff  <= pct_in;
         prod_ff <= 15'(bar_height_ff) * 15'(pct_in);
      end
      if (cmd.recip) begin
         recip_ff <= 28'(prod_ff) * 28'(RECIP_100);
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff <= bad_ff;
         if (bad_ff) begin
            rsp_dist_ff   <= '0;
            rsp_pct_ff    <= '0;
            rsp_liquid_ff <= '0;
            rsp_text_x_ff <= '0;
         end else begin
            rsp_dist_ff   <= dist_mm;
            rsp_pct_ff    <= pct_ff;
            rsp_liquid_ff <= recip_ff[RECIP_SHIFT+7:RECIP_SHIFT];
            rsp_text_x_ff <= text_x;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_distance_mm  = rsp_dist_ff;
   assign rsp_fill_percent = rsp_pct_ff;
   assign rsp_liquid_px    = rsp_liquid_ff;
   assign rsp_text_x       = rsp_text_x_ff;

endmodule

@@ hw/rtl/ufg_chk.sv @@
// port-level checker for the frame level gauge, bound to the top level
module ufg_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_frame_status,
   input logic [15:0] rsp_distance_mm,
   input logic [6:0]  rsp_fill_percent,
   input logic [7:0]  rsp_liquid_px,
   input logic [4:0]  rsp_text_x
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays and holds its distance, percent and status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance_mm)
         && $stable(rsp_fill_percent) && $stable(rsp_frame_status))
      else $error("stalled result changed");

   // a checksum mismatch carries all-zero fields
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status |-> rsp_distance_mm == 16'd0
         && rsp_fill_percent == 7'd0 && rsp_liquid_px == 8'd0 && rsp_text_x == 5'd0)
      else $error("bad frame with nonzero fields");

   // good frame: percent in range, text position matches its digit count and zero percent gives no liquid
   a_good_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_status |-> rsp_fill_percent <= 7'd100
         && ((rsp_fill_percent < 7'd10 && rsp_text_x == 5'd22)
          || (rsp_fill_percent >= 7'd10 && rsp_fill_percent < 7'd100
              && rsp_text_x == 5'd16)
          || (rsp_fill_percent == 7'd100 && rsp_text_x == 5'd10))
         && (rsp_fill_percent != 7'd0 || rsp_liquid_px == 8'd0))
      else $error("inconsistent good frame result");

endmodule

bind ultrasonic_frame_level_gauge ufg_chk u_ufg_chk (.*);
